>>> rtl/core/dfbr_pkg.sv
// ----------------------------------------------------------------------------
// dfbr_pkg: shared types and constants for the frame buffer rotation block
// Widths, reset values, register codes and buffer address helpers.
// ----------------------------------------------------------------------------
package dfbr_pkg;

  localparam int unsigned BUFFER_COUNT = 4;
  localparam int unsigned IDX_W        = $clog2(BUFFER_COUNT);

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned WIDTH_W    = 12;
  localparam int unsigned HEIGHT_W   = 12;
  localparam int unsigned BASE_W     = 28;
  localparam int unsigned BYTES_W    = 26;
  localparam int unsigned EXP_W      = WIDTH_W + HEIGHT_W + 1;
  localparam int unsigned LIM_W      = ADDR_W + 1;
  localparam int unsigned CFG_DATA_W = 28;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned NEWEST_W   = 2;

  localparam logic [ADDR_W-1:0] LOW_MASK = 32'h0fff_ffff;

  localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 12'd1920;
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 12'd1080;
  localparam logic [BASE_W-1:0]   RESET_BASE   = 28'h100_0000;
  localparam logic [BYTES_W-1:0]  RESET_BYTES  = 26'd4147200;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_REGION_BASE  = 2'd2,
    CFG_BUFFER_BYTES = 2'd3
  } cfg_reg_e;

  // Live configuration plus the values derived from it.
  typedef struct packed {
    logic [BASE_W-1:0]  base;
    logic [BYTES_W-1:0] bytes;
    logic [EXP_W-1:0]   expected;
    logic [BASE_W-1:0]  lo;
    logic [LIM_W-1:0]   hi;
  } cfg_t;

  // A buffer index together with its start address.
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] start;
  } buf_ref_t;

  typedef struct packed {
    logic [ADDR_W-1:0] new_addr;
    logic              stray;
    logic              bad_length;
  } slot_res_t;

  function automatic logic [ADDR_W-1:0] buf_start(logic [BASE_W-1:0]  base,
                                                  logic [BYTES_W-1:0] bytes,
                                                  logic [IDX_W-1:0]   idx);
    logic [ADDR_W-1:0] ofs;
    ofs = ADDR_W'(bytes) * ADDR_W'(idx);
    return ADDR_W'(base) + ofs;
  endfunction

  function automatic logic [LIM_W-1:0] region_hi(logic [BASE_W-1:0]  lo,
                                                 logic [BYTES_W-1:0] bytes);
    return LIM_W'(lo) + LIM_W'(bytes) * LIM_W'(BUFFER_COUNT);
  endfunction

  // Step the spare buffer by one, wrapping to buffer 0.
  function automatic buf_ref_t next_spare(buf_ref_t           cur,
                                          logic [BASE_W-1:0]  base,
                                          logic [BYTES_W-1:0] bytes);
    buf_ref_t nxt;
    if (cur.idx == IDX_W'(BUFFER_COUNT - 1)) begin
      nxt.idx   = '0;
      nxt.start = ADDR_W'(base);
    end else begin
      nxt.idx   = cur.idx + IDX_W'(1);
      nxt.start = cur.start + ADDR_W'(bytes);
    end
    return nxt;
  endfunction

  localparam logic [IDX_W-1:0] RESET_SLOT0  = IDX_W'(0);
  localparam logic [IDX_W-1:0] RESET_SLOT1  = IDX_W'(1);
  localparam logic [IDX_W-1:0] RESET_SPARE  = IDX_W'(2);
  localparam logic [IDX_W-1:0] RESET_LATEST = IDX_W'(3);

  localparam logic [ADDR_W-1:0] RESET_START0 = buf_start(RESET_BASE, RESET_BYTES, RESET_SLOT0);
  localparam logic [ADDR_W-1:0] RESET_START1 = buf_start(RESET_BASE, RESET_BYTES, RESET_SLOT1);
  localparam logic [ADDR_W-1:0] RESET_STARTS = buf_start(RESET_BASE, RESET_BYTES, RESET_SPARE);

endpackage

>>> rtl/core/dfbr_cfg.sv
// ----------------------------------------------------------------------------
// dfbr_cfg: configuration registers
// Holds the four registers and the expected frame length and region limits.
// ----------------------------------------------------------------------------
module dfbr_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dfbr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dfbr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output dfbr_pkg::cfg_t                 cfg_o,
  output dfbr_pkg::cfg_t                 cfg_nxt_o,
  output logic                           cfg_we_o
);
  import dfbr_pkg::*;

  logic [WIDTH_W-1:0]  width_q, width_d;
  logic [HEIGHT_W-1:0] height_q, height_d;
  logic [BASE_W-1:0]   base_q, base_d;
  logic [BYTES_W-1:0]  bytes_q, bytes_d;
  logic [EXP_W-1:0]    expected_q, expected_d;
  logic [LIM_W-1:0]    hi_q, hi_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_we_o    = cfg_valid_i;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    base_d   = base_q;
    bytes_d  = bytes_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  width_d  = cfg_data_i[WIDTH_W-1:0];
        CFG_FRAME_HEIGHT: height_d = cfg_data_i[HEIGHT_W-1:0];
        CFG_REGION_BASE:  base_d   = cfg_data_i[BASE_W-1:0];
        CFG_BUFFER_BYTES: bytes_d  = cfg_data_i[BYTES_W-1:0];
        default: ;
      endcase
    end
    // two bytes per pixel
    expected_d = (EXP_W'(width_d) * EXP_W'(height_d)) << 1;
    hi_d       = region_hi(base_d, bytes_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= RESET_WIDTH;
      height_q   <= RESET_HEIGHT;
      base_q     <= RESET_BASE;
      bytes_q    <= RESET_BYTES;
      expected_q <= (EXP_W'(RESET_WIDTH) * EXP_W'(RESET_HEIGHT)) << 1;
      hi_q       <= region_hi(RESET_BASE, RESET_BYTES);
    end else begin
      width_q    <= width_d;
      height_q   <= height_d;
      base_q     <= base_d;
      bytes_q    <= bytes_d;
      expected_q <= expected_d;
      hi_q       <= hi_d;
    end
  end

  // Base is 28 bits wide, so the masked base equals the base itself.
  assign cfg_o.base     = base_q;
  assign cfg_o.bytes    = bytes_q;
  assign cfg_o.expected = expected_q;
  assign cfg_o.lo       = base_q;
  assign cfg_o.hi       = hi_q;

  assign cfg_nxt_o.base     = base_d;
  assign cfg_nxt_o.bytes    = bytes_d;
  assign cfg_nxt_o.expected = expected_d;
  assign cfg_nxt_o.lo       = base_d;
  assign cfg_nxt_o.hi       = hi_d;

endmodule

>>> rtl/core/dfbr_slot.sv
// ----------------------------------------------------------------------------
// dfbr_slot: service of one DMA slot
// Checks length and region, rotates buffers on a complete frame.
// ----------------------------------------------------------------------------
module dfbr_slot (
  input  logic                            pending_i,
  input  logic [dfbr_pkg::ADDR_W-1:0]     addr_i,
  input  dfbr_pkg::cfg_t                  cfg_i,
  input  dfbr_pkg::buf_ref_t              slot_i,
  input  dfbr_pkg::buf_ref_t              spare_i,
  input  logic [dfbr_pkg::IDX_W-1:0]      latest_i,
  output dfbr_pkg::buf_ref_t              slot_o,
  output dfbr_pkg::buf_ref_t              spare_o,
  output logic [dfbr_pkg::IDX_W-1:0]      latest_o,
  output dfbr_pkg::slot_res_t             res_o
);
  import dfbr_pkg::*;

  logic [ADDR_W-1:0] len;
  logic              match;
  logic              take;

  assign len   = addr_i - (slot_i.start & LOW_MASK);
  assign match = (len == ADDR_W'(cfg_i.expected));
  assign take  = pending_i && match;

  always_comb begin
    slot_o   = slot_i;
    spare_o  = spare_i;
    latest_o = latest_i;
    if (take) begin
      latest_o = slot_i.idx;
      slot_o   = spare_i;
      spare_o  = next_spare(spare_i, cfg_i.base, cfg_i.bytes);
    end
  end

  assign res_o.new_addr   = pending_i ? slot_o.start : '0;
  assign res_o.stray      = pending_i && ((LIM_W'(addr_i) < LIM_W'(cfg_i.lo)) ||
                                          (LIM_W'(addr_i) > cfg_i.hi));
  assign res_o.bad_length = pending_i && !match;

endmodule

>>> rtl/core/dma_frame_buffer_rotation.sv
// ----------------------------------------------------------------------------
// dma_frame_buffer_rotation: four-buffer rotation behind two capture DMA slots
// Turns DMA interrupt events into re-arm addresses and the newest frame index.
// ----------------------------------------------------------------------------
// One item is one interrupt event. The block takes one item per clock while
// the master side takes results; each item passes through the input register
// and then the result register, and a stall holds it in either register.
// The rate is set by the slot logic between those two registers, which
// handles slot 0 and then slot 1 in the same cycle; the buffer owner state
// updates as each item leaves the input register, so the next item sees it.
// The result register and the input register form a two-entry pipe, so a
// stalled master side still lets one further item in. The expected frame
// length (width * height * 2), the region limits and the start address of
// each owned buffer are computed when a register is written, so they are
// ready for the next item. Write configuration only while no item is in
// flight. newest_frame carries the low two bits of the buffer index.
// ----------------------------------------------------------------------------
module dma_frame_buffer_rotation (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dfbr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dfbr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // event stream in
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [31:0] first_end_address, [63:32] second_end_address
  input  logic [63:0]                     s_axis_tdata_i,
  // [0] first_pending, [1] second_pending
  input  logic [1:0]                      s_axis_tuser_i,
  // result stream out
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [31:0] first_new_address, [63:32] second_new_address, [65:64] newest_frame,
  // [66] first_stray, [67] second_stray, [68] first_bad_length,
  // [69] second_bad_length, [71:70] zero
  output logic [71:0]                     m_axis_tdata_o,
  // [0] first_rearm, [1] second_rearm
  output logic [1:0]                      m_axis_tuser_o
);
  import dfbr_pkg::*;

  cfg_t cfg, cfg_nxt;
  logic cfg_we;

  dfbr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .cfg_nxt_o   (cfg_nxt),
    .cfg_we_o    (cfg_we)
  );

  // Input register
  logic              in_valid_q;
  logic              in_p0_q, in_p1_q;
  logic [ADDR_W-1:0] in_a0_q, in_a1_q;

  // Buffer ownership
  buf_ref_t         slot0_q, slot1_q, spare_q;
  logic [IDX_W-1:0] latest_q;

  // Result register
  logic              out_valid_q;
  logic              out_rearm0_q, out_rearm1_q;
  slot_res_t         out_res0_q, out_res1_q;
  logic [NEWEST_W-1:0] out_newest_q;

  logic advance;
  logic s_accept;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  // Slot 0 first, then slot 1 on what slot 0 leaves behind.
  buf_ref_t         slot0_nxt, slot1_nxt, spare_mid, spare_nxt;
  logic [IDX_W-1:0] latest_mid, latest_nxt;
  slot_res_t        res0, res1;

  dfbr_slot u_slot0 (
    .pending_i (in_p0_q),
    .addr_i    (in_a0_q),
    .cfg_i     (cfg),
    .slot_i    (slot0_q),
    .spare_i   (spare_q),
    .latest_i  (latest_q),
    .slot_o    (slot0_nxt),
    .spare_o   (spare_mid),
    .latest_o  (latest_mid),
    .res_o     (res0)
  );

  dfbr_slot u_slot1 (
    .pending_i (in_p1_q),
    .addr_i    (in_a1_q),
    .cfg_i     (cfg),
    .slot_i    (slot1_q),
    .spare_i   (spare_mid),
    .latest_i  (latest_mid),
    .slot_o    (slot1_nxt),
    .spare_o   (spare_nxt),
    .latest_o  (latest_nxt),
    .res_o     (res1)
  );

  // Control: pipe valids and buffer ownership.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      slot0_q.idx   <= RESET_SLOT0;
      slot0_q.start <= RESET_START0;
      slot1_q.idx   <= RESET_SLOT1;
      slot1_q.start <= RESET_START1;
      spare_q.idx   <= RESET_SPARE;
      spare_q.start <= RESET_STARTS;
      latest_q      <= RESET_LATEST;
    end else begin
      if (s_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end

      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we) begin
        // recompute start addresses of the owned buffers from the new layout
        slot0_q.start <= buf_start(cfg_nxt.base, cfg_nxt.bytes, slot0_q.idx);
        slot1_q.start <= buf_start(cfg_nxt.base, cfg_nxt.bytes, slot1_q.idx);
        spare_q.start <= buf_start(cfg_nxt.base, cfg_nxt.bytes, spare_q.idx);
      end else if (advance) begin
        slot0_q  <= slot0_nxt;
        slot1_q  <= slot1_nxt;
        spare_q  <= spare_nxt;
        latest_q <= latest_nxt;
      end
    end
  end

  // Payload: hold while stalled.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_p0_q <= s_axis_tuser_i[0];
      in_p1_q <= s_axis_tuser_i[1];
      in_a0_q <= s_axis_tdata_i[31:0];
      in_a1_q <= s_axis_tdata_i[63:32];
    end
    if (advance) begin
      out_rearm0_q <= in_p0_q;
      out_rearm1_q <= in_p1_q;
      out_res0_q   <= res0;
      out_res1_q   <= res1;
      out_newest_q <= NEWEST_W'(latest_nxt);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = {out_rearm1_q, out_rearm0_q};
  assign m_axis_tdata_o  = {2'b00,
                            out_res1_q.bad_length, out_res0_q.bad_length,
                            out_res1_q.stray, out_res0_q.stray,
                            out_newest_q,
                            out_res1_q.new_addr, out_res0_q.new_addr};

`ifndef NO_ASSERTIONS
  // A result only appears after an item sat in the input register.
  a_out_from_in : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(in_valid_q))
    else $error("result appeared without a pending item");

  // The rearm flag of a result follows the pending flag of its item.
  a_rearm_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_rearm0_q == $past(in_p0_q)) && (out_rearm1_q == $past(in_p1_q)))
    else $error("rearm flag does not match pending flag");

  // Newest frame changes only when an item is processed.
  a_latest_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(latest_q))
    else $error("latest buffer moved without an item");

  // A bad length is only reported for a slot that is re-armed.
  a_bad_needs_rearm : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !((out_res0_q.bad_length && !out_rearm0_q) ||
                      (out_res1_q.bad_length && !out_rearm1_q)))
    else $error("bad length on an idle slot");
`endif

endmodule
